// File: hdl/mabts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mabts_pkg
// Shared types, widths and codes for the moving average band trade signal.
// ----------------------------------------------------------------------------
package mabts_pkg;

  localparam int WINDOW_DEFAULT = 5;

  localparam int PRICE_W  = 24;
  localparam int FACTOR_W = 16;
  localparam int FRAC_W   = 15;
  localparam int ACTION_W = 2;
  localparam int TGAIN_W  = 25;
  localparam int TOTAL_W  = 48;
  localparam int COUNT_W  = 32;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_BITS   = ACTION_W + TGAIN_W + TOTAL_W + COUNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_BUY_FACTOR  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SELL_FACTOR = 2'd1;

  localparam logic [FACTOR_W-1:0] BUY_FACTOR_RESET  = 16'd31785;
  localparam logic [FACTOR_W-1:0] SELL_FACTOR_RESET = 16'd33751;

  localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_OPEN  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLOSE = 2'd2;

  // one word moving from the input register into the result register
  typedef struct packed {
    logic step;
    logic clear;
  } step_ctrl_t;

endpackage

// File: hdl/moving_average_band_trade_signal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_band_trade_signal
// Buy/sell signal from a price envelope around a moving average.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one price word, s_tuser flags the start of a new series
//   (window, position, total and count are cleared before that price).
//   m_tdata returns one result word per price: action, trade gain, running
//   total and closed trade count.
//   buy and sell band factors (Q1.15) are written through cfg_we/cfg_index/
//   cfg_data while the stream is idle; unknown indexes are ignored.
// Timing:
//   one word per clock sustained while m_tready stays high; a price accepted
//   passes through the input register and then the result register before
//   it shows on m_tdata. The rate is set by the state loop: running window
//   sum, the two band multiplies, the compare and the 48-bit saturating
//   accumulate all close within it, with no register between them.
// Reset:
//   rst clears the series state and both handshake stages and loads the
//   default band factors (0.97 and 1.03).
// Stall:
//   while m_tready is low the result is held; the input register still takes
//   a word if it is empty, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module moving_average_band_trade_signal #(
  parameter int WINDOW = mabts_pkg::WINDOW_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mabts_pkg::IN_DATA_W-1:0]     s_tdata,   // price[23:0]
  input  logic                                s_tuser,   // start_series
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // action[1:0], trade_gain[26:2], total_gain[74:27], trades_done[106:75]
  output logic [mabts_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                                cfg_we,
  input  logic [mabts_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mabts_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mabts_pkg::*;

  localparam int SUM_W = PRICE_W + $clog2(WINDOW);

  logic [FACTOR_W-1:0] buy_factor;
  logic [FACTOR_W-1:0] sell_factor;

  logic               in_valid;
  logic [PRICE_W-1:0] in_price;
  logic               in_start;
  logic               advance;
  step_ctrl_t         ctrl;

  logic [SUM_W-1:0]    win_sum;
  logic                win_full;
  logic [ACTION_W-1:0] action;
  logic [TGAIN_W-1:0]  trade_gain;
  logic [TOTAL_W-1:0]  total_gain;
  logic [COUNT_W-1:0]  trades_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      buy_factor  <= BUY_FACTOR_RESET;
      sell_factor <= SELL_FACTOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BUY_FACTOR:  buy_factor  <= cfg_data;
        REG_SELL_FACTOR: sell_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance    = ~m_tvalid | m_tready;
  assign s_tready   = ~in_valid | advance;
  assign ctrl.step  = in_valid & advance;
  assign ctrl.clear = in_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_price <= s_tdata[PRICE_W-1:0];
      in_start <= s_tuser;
    end
  end

  mabts_window #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_window (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .price (in_price),
    .sum   (win_sum),
    .full  (win_full)
  );

  mabts_decide #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_decide (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .price       (in_price),
    .sum         (win_sum),
    .full        (win_full),
    .buy_factor  (buy_factor),
    .sell_factor (sell_factor),
    .action      (action),
    .trade_gain  (trade_gain),
    .total_gain  (total_gain),
    .trades_done (trades_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      m_tdata <= OUT_DATA_W'({trades_done, total_gain, trade_gain, action});
    end
  end

endmodule

// File: hdl/mabts_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mabts_window
// Price shift line with running sum and fill count.
// ----------------------------------------------------------------------------
module mabts_window #(
  parameter int WINDOW = mabts_pkg::WINDOW_DEFAULT,
  parameter int SUM_W  = mabts_pkg::PRICE_W + $clog2(WINDOW)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mabts_pkg::step_ctrl_t        ctrl,
  input  logic [mabts_pkg::PRICE_W-1:0] price,
  output logic [SUM_W-1:0]             sum,
  output logic                         full
);
  import mabts_pkg::*;

  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW);

  logic [PRICE_W-1:0] taps [WINDOW];
  logic [FILL_W-1:0]  fill_count;
  logic [FILL_W-1:0]  fill_count_next;
  logic [SUM_W-1:0]   sum_next;
  logic [SUM_W-1:0]   oldest;
  logic               held_full;

  assign held_full = (fill_count == FILL_MAX);
  // a cleared series compares nothing on this word
  assign full      = held_full & ~ctrl.clear;

  // the leaving price only counts once the line is full
  assign oldest = held_full ? SUM_W'(taps[0]) : '0;

  always_comb begin
    if (ctrl.clear) begin
      sum_next        = SUM_W'(price);
      fill_count_next = FILL_W'(1);
    end else begin
      sum_next        = sum + SUM_W'(price) - oldest;
      fill_count_next = held_full ? fill_count : fill_count + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum        <= '0;
      fill_count <= '0;
    end else if (ctrl.step) begin
      sum        <= sum_next;
      fill_count <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        taps[i] <= taps[i + 1];
      end
      taps[WINDOW - 1] <= price;
    end
  end

endmodule

// File: hdl/mabts_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mabts_decide
// Band compare, position tracking and saturating profit and trade count.
// ----------------------------------------------------------------------------
module mabts_decide #(
  parameter int WINDOW = mabts_pkg::WINDOW_DEFAULT,
  parameter int SUM_W  = mabts_pkg::PRICE_W + $clog2(WINDOW)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mabts_pkg::step_ctrl_t           ctrl,
  input  logic [mabts_pkg::PRICE_W-1:0]   price,
  input  logic [SUM_W-1:0]                sum,
  input  logic                            full,
  input  logic [mabts_pkg::FACTOR_W-1:0]  buy_factor,
  input  logic [mabts_pkg::FACTOR_W-1:0]  sell_factor,
  output logic [mabts_pkg::ACTION_W-1:0]  action,
  output logic [mabts_pkg::TGAIN_W-1:0]   trade_gain,
  output logic [mabts_pkg::TOTAL_W-1:0]   total_gain,
  output logic [mabts_pkg::COUNT_W-1:0]   trades_done
);
  import mabts_pkg::*;

  localparam int PROD_W = SUM_W + FACTOR_W;

  logic               holding;
  logic [PRICE_W-1:0] entry_price;
  logic [TOTAL_W-1:0] gain_sum;
  logic [COUNT_W-1:0] trade_tally;

  logic               holding_cur;
  logic [PRICE_W-1:0] entry_cur;
  logic [TOTAL_W-1:0] gain_sum_cur;
  logic [COUNT_W-1:0] tally_cur;

  logic [SUM_W-1:0]   scaled_price;
  logic [PROD_W-1:0]  lhs;
  logic [PROD_W-1:0]  low_band;
  logic [PROD_W-1:0]  high_band;
  logic               below_low;
  logic               buy_arm;
  logic               do_open;
  logic               do_close;
  logic [TGAIN_W-1:0] gain;
  logic [TOTAL_W:0]   wide_sum;
  logic [TOTAL_W-1:0] sat_sum;

  logic               holding_next;
  logic [PRICE_W-1:0] entry_price_next;
  logic [TOTAL_W-1:0] gain_sum_next;
  logic [COUNT_W-1:0] trade_tally_next;

  // start of a series sees cleared state
  assign holding_cur  = holding & ~ctrl.clear;
  assign entry_cur    = ctrl.clear ? '0 : entry_price;
  assign gain_sum_cur = ctrl.clear ? '0 : gain_sum;
  assign tally_cur    = ctrl.clear ? '0 : trade_tally;

  // price*WINDOW*2^15 against sum*factor, all exact
  assign scaled_price = SUM_W'(price) * SUM_W'(WINDOW);
  assign lhs          = {1'b0, scaled_price, {FRAC_W{1'b0}}};
  assign low_band     = PROD_W'(sum) * PROD_W'(buy_factor);
  assign high_band    = PROD_W'(sum) * PROD_W'(sell_factor);

  assign below_low = (lhs < low_band);
  assign buy_arm   = full & below_low & ~holding_cur;
  assign do_open   = buy_arm & (price != '0);
  assign do_close  = full & ~buy_arm & (lhs > high_band) & holding_cur;

  assign gain = do_close ? (TGAIN_W'(price) - TGAIN_W'(entry_cur)) : '0;

  assign wide_sum = {gain_sum_cur[TOTAL_W-1], gain_sum_cur}
                  + {{(TOTAL_W + 1 - TGAIN_W){gain[TGAIN_W-1]}}, gain};

  always_comb begin
    if (wide_sum[TOTAL_W] != wide_sum[TOTAL_W-1]) begin
      // clamp toward the sign of the true sum
      sat_sum = wide_sum[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}}
                                  : {1'b0, {(TOTAL_W-1){1'b1}}};
    end else begin
      sat_sum = wide_sum[TOTAL_W-1:0];
    end
  end

  always_comb begin
    holding_next     = holding_cur;
    entry_price_next = entry_cur;
    gain_sum_next    = gain_sum_cur;
    trade_tally_next = tally_cur;
    action           = ACT_NONE;
    if (do_open) begin
      holding_next     = 1'b1;
      entry_price_next = price;
      action           = ACT_OPEN;
    end else if (do_close) begin
      holding_next     = 1'b0;
      entry_price_next = '0;
      gain_sum_next    = sat_sum;
      if (tally_cur != '1) begin
        trade_tally_next = tally_cur + COUNT_W'(1);
      end
      action = ACT_CLOSE;
    end
  end

  assign trade_gain  = gain;
  assign total_gain  = gain_sum_next;
  assign trades_done = trade_tally_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      holding     <= 1'b0;
      entry_price <= '0;
      gain_sum    <= '0;
      trade_tally <= '0;
    end else if (ctrl.step) begin
      holding     <= holding_next;
      entry_price <= entry_price_next;
      gain_sum    <= gain_sum_next;
      trade_tally <= trade_tally_next;
    end
  end

endmodule
